// ===== hw/rtl/scd_pkg.sv =====
// shared types and constants for the serial command deframer
// no dependencies; used by scd_ctrl, scd_datapath and the top level
package scd_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 20;

  localparam logic [7:0] START_BYTE = 8'h01;
  localparam logic [7:0] END_BYTE   = 8'h04;

  localparam logic [1:0] ST_GOOD     = 2'd0;
  localparam logic [1:0] ST_BAD_END  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic ld_len;
    logic ld_cmd;
    logic wr_byte;
    logic emit_bad;
    logic emit_ovf;
    logic emit_zero;
    logic emit_data;
    logic rd_next;
  } scd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_start;
    logic is_end;
    logic cnt_eq_len;
    logic cnt_full;
    logic len_zero;
    logic last_idx;
    logic out_free;
  } scd_stat_t;

endpackage

// ===== hw/rtl/scd_ctrl.sv =====
// frame parser state machine for the serial command deframer
// depends on scd_pkg; drives scd_datapath through command signals
module scd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  scd_pkg::scd_stat_t  stat,
  output scd_pkg::scd_cmd_t   cmd
);
  import scd_pkg::*;

  localparam logic [2:0] S_WAIT = 3'd0;
  localparam logic [2:0] S_LEN  = 3'd1;
  localparam logic [2:0] S_CMD  = 3'd2;
  localparam logic [2:0] S_DATA = 3'd3;
  localparam logic [2:0] S_READ = 3'd4;
  localparam logic [2:0] S_LOAD = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       in_take;

  // only a byte in the data phase can produce a result right away
  assign in_stall = !((state == S_WAIT) || (state == S_LEN) || (state == S_CMD) ||
                      ((state == S_DATA) && stat.out_free));
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_WAIT: begin
        if (in_take && stat.is_start) begin
          state_next = S_LEN;
        end
      end
      S_LEN: begin
        if (in_take) begin
          cmd.ld_len = 1'b1;
          state_next = S_CMD;
        end
      end
      S_CMD: begin
        if (in_take) begin
          cmd.ld_cmd = 1'b1;
          state_next = S_DATA;
        end
      end
      S_DATA: begin
        if (in_take) begin
          if (stat.cnt_eq_len) begin
            if (!stat.is_end) begin
              cmd.emit_bad = 1'b1;
              state_next   = S_WAIT;
            end else if (stat.len_zero) begin
              cmd.emit_zero = 1'b1;
              state_next    = S_WAIT;
            end else begin
              state_next = S_READ;
            end
          end else if (stat.cnt_full) begin
            cmd.emit_ovf = 1'b1;
            state_next   = S_WAIT;
          end else begin
            cmd.wr_byte = 1'b1;
          end
        end
      end
      S_READ: begin
        // store read data lands at the end of this cycle
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (stat.out_free) begin
          cmd.emit_data = 1'b1;
          if (stat.last_idx) begin
            state_next = S_WAIT;
          end else begin
            cmd.rd_next = 1'b1;
            state_next  = S_READ;
          end
        end
      end
      default: begin
        state_next = S_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_WAIT;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_one_emit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.emit_bad, cmd.emit_ovf, cmd.emit_zero, cmd.emit_data}))
    else $error("more than one result loaded in a cycle");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_bad || cmd.emit_ovf || cmd.emit_zero || cmd.emit_data) |-> stat.out_free)
    else $error("result loaded over an untaken result");

  a_read_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> (state == S_LOAD))
    else $error("store read not followed by load");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_data && stat.last_idx) |=> (state == S_WAIT))
    else $error("run did not end after last payload byte");
`endif

endmodule

// ===== hw/rtl/scd_datapath.sv =====
// frame registers, payload store and result register of the deframer
// depends on scd_pkg; steered by scd_ctrl
module scd_datapath #(
  parameter int unsigned MAX_PAYLOAD = scd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          rx_byte,
  input  scd_pkg::scd_cmd_t   cmd,
  output scd_pkg::scd_stat_t  stat,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic [7:0]          command,
  output logic [4:0]          length,
  output logic [7:0]          payload_byte,
  output logic [4:0]          payload_index,
  output logic                last
);
  import scd_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [7:0]        frame_length;
  logic [7:0]        frame_command;
  logic [CNT_W-1:0]  cnt;
  logic [ADDR_W-1:0] rd_idx;
  logic [7:0]        rd_data;
  logic [7:0]        payload_store [MAX_PAYLOAD];
  logic              any_emit;

  assign stat.is_start   = (rx_byte == START_BYTE);
  assign stat.is_end     = (rx_byte == END_BYTE);
  assign stat.cnt_eq_len = (8'(cnt) == frame_length);
  assign stat.cnt_full   = (cnt == CNT_W'(MAX_PAYLOAD));
  assign stat.len_zero   = (frame_length == 8'd0);
  assign stat.last_idx   = ((8'(rd_idx) + 8'd1) == frame_length);
  assign stat.out_free   = !out_valid || !out_stall;

  assign any_emit = cmd.emit_bad || cmd.emit_ovf || cmd.emit_zero || cmd.emit_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length  <= '0;
      frame_command <= '0;
      cnt           <= '0;
      rd_idx        <= '0;
    end else begin
      if (cmd.ld_len) begin
        frame_length <= rx_byte;
      end
      if (cmd.ld_cmd) begin
        frame_command <= rx_byte;
        cnt           <= '0;
        rd_idx        <= '0;
      end
      if (cmd.wr_byte) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (cmd.rd_next) begin
        rd_idx <= rd_idx + ADDR_W'(1);
      end
    end
  end

  // payload store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_byte) begin
      payload_store[cnt[ADDR_W-1:0]] <= rx_byte;
    end
    rd_data <= payload_store[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (any_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_bad || cmd.emit_ovf) begin
      status        <= cmd.emit_bad ? ST_BAD_END : ST_OVERFLOW;
      command       <= 8'd0;
      length        <= 5'd0;
      payload_byte  <= 8'd0;
      payload_index <= 5'd0;
      last          <= 1'b1;
    end else if (cmd.emit_zero) begin
      status        <= ST_GOOD;
      command       <= frame_command;
      length        <= 5'd0;
      payload_byte  <= 8'd0;
      payload_index <= 5'd0;
      last          <= 1'b1;
    end else if (cmd.emit_data) begin
      status        <= ST_GOOD;
      command       <= frame_command;
      length        <= frame_length[4:0];
      payload_byte  <= rd_data;
      payload_index <= 5'(rd_idx);
      last          <= stat.last_idx;
    end
  end

endmodule

// ===== hw/rtl/serial_command_deframer_core.sv =====
// Serial command deframer: recovers frames of start byte 0x01, length, command,
// payload and end byte 0x04 from a byte stream. Start, length and command bytes
// are always taken; a byte in the payload phase, the end byte included, is
// taken only when the result register is free. A good frame is then replayed from
// the payload store one result at a time (store read, then load of the result
// register, which waits out any output stall), so a frame of n payload bytes
// holds the input after its end byte until all n results are loaded. Failed
// frames and empty frames give a single result at once.
module serial_command_deframer_core #(
  parameter int unsigned MAX_PAYLOAD = scd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output logic [7:0] command,
  output logic [4:0] length,
  output logic [7:0] payload_byte,
  output logic [4:0] payload_index,
  output logic       last
);
  import scd_pkg::*;

  scd_cmd_t  cmd;
  scd_stat_t stat;

  scd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  scd_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .rx_byte       (rx_byte),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .command       (command),
    .length        (length),
    .payload_byte  (payload_byte),
    .payload_index (payload_index),
    .last          (last)
  );

endmodule

// ===== test/testbench.sv =====
// testbench for serial_command_deframer_core: directed byte table, then random frames
// checked against a behavioral deframer; depends on scd_pkg and the core module only
`timescale 1ns / 100ps

module testbench;
  import scd_pkg::*;

  localparam int PAYLOAD_DEPTH = MAX_PAYLOAD_DEF;
  localparam int POS_WAIT = 0;
  localparam int POS_LEN = 1;
  localparam int POS_CMD = 2;
  localparam int POS_BODY = 3;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 64;
  localparam int NUM_PHASES = 4;
  localparam int PHASE_BYTES = 100;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] command;
    logic [4:0] length;
    logic [7:0] payload_byte;
    logic [4:0] payload_index;
    logic       last;
  } frame_result_t;

  typedef struct packed {
    logic [7:0]    rx;
    logic          typed;
    frame_result_t res;
  } stim_row_t;

  localparam frame_result_t NO_RES = '0;
  localparam frame_result_t BAD_END_RES = {ST_BAD_END, 8'h00, 5'd0, 8'h00, 5'd0, 1'b1};
  localparam frame_result_t OVERFLOW_RES = {ST_OVERFLOW, 8'h00, 5'd0, 8'h00, 5'd0, 1'b1};

  localparam int NUM_ROWS = 27;
  localparam stim_row_t DIRECTED [NUM_ROWS] = '{
    // bytes outside a frame are dropped
    {8'h00, 1'b0, NO_RES},
    {8'hFF, 1'b0, NO_RES},
    {END_BYTE, 1'b0, NO_RES},
    // empty frame, command 0xff
    {START_BYTE, 1'b0, NO_RES},
    {8'h00, 1'b0, NO_RES},
    {8'hFF, 1'b0, NO_RES},
    {END_BYTE, 1'b1, {ST_GOOD, 8'hFF, 5'd0, 8'h00, 5'd0, 1'b1}},
    // empty frame with wrong end byte
    {START_BYTE, 1'b0, NO_RES},
    {8'h00, 1'b0, NO_RES},
    {8'h00, 1'b0, NO_RES},
    {8'hFE, 1'b1, BAD_END_RES},
    // one payload byte, wrong end byte
    {START_BYTE, 1'b0, NO_RES},
    {8'h01, 1'b0, NO_RES},
    {8'h55, 1'b0, NO_RES},
    {8'hAA, 1'b0, NO_RES},
    {8'h05, 1'b1, BAD_END_RES},
    // two payload bytes at the extremes
    {START_BYTE, 1'b0, NO_RES},
    {8'h02, 1'b0, NO_RES},
    {8'hAA, 1'b0, NO_RES},
    {8'h00, 1'b0, NO_RES},
    {8'hFF, 1'b0, NO_RES},
    {END_BYTE, 1'b0, NO_RES},
    // start byte used as length, command and payload
    {START_BYTE, 1'b0, NO_RES},
    {START_BYTE, 1'b0, NO_RES},
    {START_BYTE, 1'b0, NO_RES},
    {START_BYTE, 1'b0, NO_RES},
    {END_BYTE, 1'b0, NO_RES}
  };

  localparam int IDLE_PCT [NUM_PHASES] = '{0, 48, 0, 13};
  localparam int STALL_PCT [NUM_PHASES] = '{0, 0, 48, 13};

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] status;
  logic [7:0] command;
  logic [4:0] length;
  logic [7:0] payload_byte;
  logic [4:0] payload_index;
  logic       last;

  // behavioral deframer state
  int         frame_pos = POS_WAIT;
  logic [7:0] frame_len = 8'h00;
  logic [7:0] frame_cmd = 8'h00;
  logic [7:0] payload_mirror [PAYLOAD_DEPTH];

  frame_result_t fresh_results [$];
  frame_result_t awaited_results [$];
  frame_result_t got_res;
  frame_result_t want_res;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  int shown_count = 0;
  int counted_bytes = 0;
  int checked_results = 0;
  int good_frames = 0;
  int failed_frames = 0;
  int quiet_cycles = 0;

  serial_command_deframer_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .command      (command),
    .length       (length),
    .payload_byte (payload_byte),
    .payload_index(payload_index),
    .last         (last)
  );

  always #5 clk = ~clk;

  // advance the deframer by one byte, leaving the results it causes in fresh_results
  task automatic deframe_byte(input logic [7:0] b);
    int cnt;
    fresh_results.delete();
    case (frame_pos)
      POS_WAIT: begin
        if (b == START_BYTE) frame_pos = POS_LEN;
      end
      POS_LEN: begin
        frame_len = b;
        frame_pos = POS_CMD;
      end
      POS_CMD: begin
        frame_cmd = b;
        frame_pos = POS_BODY;
      end
      default: begin
        cnt = frame_pos - POS_BODY;
        if (cnt == int'(frame_len)) begin
          frame_pos = POS_WAIT;
          if (b != END_BYTE) begin
            fresh_results.push_back(BAD_END_RES);
          end else if (frame_len == 8'h00) begin
            fresh_results.push_back({ST_GOOD, frame_cmd, 5'd0, 8'h00, 5'd0, 1'b1});
          end else begin
            for (int i = 0; i < cnt; i++)
              fresh_results.push_back({ST_GOOD, frame_cmd, frame_len[4:0], payload_mirror[i],
                                       5'(i), i == cnt - 1});
          end
        end else if (cnt >= PAYLOAD_DEPTH) begin
          // store full and no end in sight: byte dropped
          frame_pos = POS_WAIT;
          fresh_results.push_back(OVERFLOW_RES);
        end else begin
          payload_mirror[cnt] = b;
          frame_pos = frame_pos + 1;
        end
      end
    endcase
  endtask

  // offer one byte, wait for it to be taken, then queue what it should produce
  task automatic send_byte(input logic [7:0] b, input logic typed, input frame_result_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!(frame_pos == POS_WAIT && b != START_BYTE)) counted_bytes++;
    deframe_byte(b);
    if (typed) begin
      awaited_results.push_back(res);
    end else begin
      foreach (fresh_results[k]) awaited_results.push_back(fresh_results[k]);
    end
  endtask

  task automatic send_random_burst();
    int pick;
    int len;
    int body;
    logic [7:0] tail;
    pick = $urandom_range(99);
    if (pick < 60) begin
      if (pick < 45) len = $urandom_range(5);
      else if (pick < 55) len = $urandom_range(20, 6);
      else len = PAYLOAD_DEPTH;
      tail = ($urandom_range(99) < 85) ? END_BYTE : 8'($urandom_range(255));
      send_byte(START_BYTE, 1'b0, NO_RES);
      send_byte(8'(len), 1'b0, NO_RES);
      send_byte(8'($urandom_range(255)), 1'b0, NO_RES);
      repeat (len) send_byte(8'($urandom_range(255)), 1'b0, NO_RES);
      send_byte(tail, 1'b0, NO_RES);
    end else if (pick < 70) begin
      // length beyond the store: one byte past the end overflows
      send_byte(START_BYTE, 1'b0, NO_RES);
      send_byte(8'($urandom_range(255, PAYLOAD_DEPTH + 1)), 1'b0, NO_RES);
      send_byte(8'($urandom_range(255)), 1'b0, NO_RES);
      repeat (PAYLOAD_DEPTH + 1) send_byte(8'($urandom_range(255)), 1'b0, NO_RES);
    end else if (pick < 80) begin
      // cut-off frame, later bytes land inside it
      len = $urandom_range(8, 1);
      body = $urandom_range(len - 1);
      send_byte(START_BYTE, 1'b0, NO_RES);
      send_byte(8'(len), 1'b0, NO_RES);
      send_byte(8'($urandom_range(255)), 1'b0, NO_RES);
      repeat (body) send_byte(8'($urandom_range(255)), 1'b0, NO_RES);
    end else begin
      repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)), 1'b0, NO_RES);
    end
  endtask

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got_res = {status, command, length, payload_byte, payload_index, last};
      checked_results++;
      if (awaited_results.size() == 0) begin
        fail_count++;
        if (shown_count < MAX_SHOWN) begin
          shown_count++;
          $display("unexpected result: status %0d command %h length %0d byte %h index %0d last %0d",
                   status, command, length, payload_byte, payload_index, last);
        end
      end else begin
        want_res = awaited_results.pop_front();
        if (got_res.last) begin
          if (got_res.status == ST_GOOD) good_frames++;
          else failed_frames++;
        end
        if (got_res.status != want_res.status || got_res.command != want_res.command ||
            got_res.length != want_res.length || got_res.payload_byte != want_res.payload_byte ||
            got_res.payload_index != want_res.payload_index || got_res.last != want_res.last) begin
          fail_count++;
          if (shown_count < MAX_SHOWN) begin
            shown_count++;
            $display("mismatch: expected status %0d command %h length %0d byte %h index %0d last %0d",
                     want_res.status, want_res.command, want_res.length,
                     want_res.payload_byte, want_res.payload_index, want_res.last);
            $display("          actual   status %0d command %h length %0d byte %h index %0d last %0d",
                     status, command, length, payload_byte, payload_index, last);
          end
        end
      end
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < NUM_ROWS; r++)
      send_byte(DIRECTED[r].rx, DIRECTED[r].typed, DIRECTED[r].res);

    for (int p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct = IDLE_PCT[p];
      recv_stall_pct = STALL_PCT[p];
      while (counted_bytes < NUM_ROWS + PHASE_BYTES * (p + 1)) send_random_burst();
      // hold off until the block has handed over everything owed
      in_valid <= 1'b0;
      @(posedge clk);
      while (awaited_results.size() != 0) @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0) begin
      fail_count += awaited_results.size();
      $display("%0d expected results never arrived", awaited_results.size());
    end

    $display("%0d frame bytes sent, %0d results checked", counted_bytes, checked_results);
    $display("%0d good frames, %0d bad-end or overflow frames, %0d failures",
             good_frames, failed_frames, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
